[design/hpr_pkg.sv]
// ----------------------------------------------------------------------------
// hpr_pkg: shared types and constants of the heading PD rotation command core
// Fixed-point constants, field widths and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package hpr_pkg;

  localparam int ROBOT_SLOTS = 16;

  localparam int SLOT_W = 4;
  localparam int HEAD_W = 16;
  localparam int GAIN_W = 16;
  localparam int CMD_W  = 24;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;

  // configuration register indexes
  localparam logic [1:0] REG_PROP_GAIN     = 2'd0;
  localparam logic [1:0] REG_DAMP_GAIN     = 2'd1;
  localparam logic [1:0] REG_INV_STEP_TIME = 2'd2;

  localparam logic [15:0] PROP_GAIN_RST     = 16'd256;
  localparam logic [15:0] DAMP_GAIN_RST     = 16'd0;
  localparam logic [15:0] INV_STEP_TIME_RST = 16'd100;

  localparam logic [15:0] TWO_PI_Q13      = 16'd51472;
  localparam logic [21:0] DEG_PER_RAD_Q16 = 22'd3754937;
  localparam logic [15:0] DEG180_Q7       = 16'd23040;
  localparam logic [15:0] DEG360_Q7       = 16'd46080;
  localparam logic [10:0] RAD_PER_DEG_Q16 = 11'd1144;

  localparam logic signed [CMD_W-1:0] CMD_MAX = 24'sh7FFFFF;
  localparam logic signed [CMD_W-1:0] CMD_MIN = 24'sh800000;

  typedef struct packed {
    logic in_load;
    logic conv;
    logic err;
    logic deriv;
    logic sum;
    logic out_load;
  } hpr_cmd_t;

  // signed Q2.13 radians to unsigned Q9.7 degrees in 0..360
  function automatic logic [15:0] to_degrees(input logic [15:0] rad);
    logic [15:0] rad_u;
    logic [37:0] prod;
    rad_u = rad[15] ? (rad + TWO_PI_Q13) : rad;
    prod  = 38'(rad_u) * 38'(DEG_PER_RAD_Q16);
    prod  = prod + 38'(1 << 21);
    return prod[37:22];
  endfunction

endpackage

[design/hpr_ctrl.sv]
// ----------------------------------------------------------------------------
// hpr_ctrl: sequencing controller
// Steps one item through the datapath and owns the channel handshakes.
// ----------------------------------------------------------------------------
module hpr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output hpr_pkg::hpr_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_ERR,
    S_DERIV,
    S_SUM,
    S_SCALE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.in_load = 1'b1;
          state_nxt   = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv  = 1'b1;
        state_nxt = S_ERR;
      end
      S_ERR: begin
        cmd.err   = 1'b1;
        state_nxt = S_DERIV;
      end
      S_DERIV: begin
        cmd.deriv = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        // hold the finished item until the output register is free
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

[design/hpr_dpath.sv]
// ----------------------------------------------------------------------------
// hpr_dpath: heading error and PD command datapath
// Angle conversion, wrap and fold, per-slot derivative state, gain products,
// scaling to rad/s with saturation, gain registers and the output register.
// ----------------------------------------------------------------------------
module hpr_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  hpr_pkg::hpr_cmd_t                cmd,
  input  logic [hpr_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             cfg_wr,
  input  logic [1:0]                       cfg_addr,
  input  logic [15:0]                      cfg_data,
  output logic [hpr_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int SW = hpr_pkg::SLOT_W;
  localparam int CW = hpr_pkg::CMD_W;

  // gain registers
  logic [15:0] prop_gain_r, damp_gain_r, inv_step_r;

  // per-slot state
  logic [15:0]          prev_mag_r [hpr_pkg::ROBOT_SLOTS];
  logic signed [CW-1:0] last_der_r [hpr_pkg::ROBOT_SLOTS];

  // item pipeline registers
  logic [SW-1:0]        slot_r;
  logic                 slot_ok_r;
  logic [15:0]          lead_r, robo_r;
  logic [15:0]          deg_l_r, deg_r_r;
  logic [15:0]          err_r;
  logic                 plus_r;
  logic                 prev_nz_r;
  logic signed [CW-1:0] old_der_r;
  logic signed [16:0]   delta_r;
  logic signed [CW-1:0] deriv_r;
  logic [31:0]          kp_r;
  logic [30:0]          mag31_r;
  logic                 big_r;
  logic                 neg_r;

  // output register
  logic [SW-1:0]        out_slot_r;
  logic [CW-1:0]        out_cmd_r;
  logic                 out_cw_r;

  // error step
  logic signed [16:0]   diff;
  logic [15:0]          mag;
  logic                 far;
  logic [15:0]          err_nxt;
  logic [15:0]          prev_sel;
  logic signed [CW-1:0] der_sel;

  // derivative step
  logic signed [33:0]   d_full;
  logic signed [CW-1:0] d_sat;
  logic signed [CW-1:0] deriv_nxt;

  // sum step
  logic signed [40:0]   dd;
  logic signed [41:0]   sum;
  logic signed [41:0]   v;
  logic [41:0]          vabs;

  // scale step
  logic [41:0]          scaled;
  logic [23:0]          m;
  logic [CW-1:0]        cmd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r <= hpr_pkg::PROP_GAIN_RST;
      damp_gain_r <= hpr_pkg::DAMP_GAIN_RST;
      inv_step_r  <= hpr_pkg::INV_STEP_TIME_RST;
    end else if (cfg_wr) begin
      unique case (cfg_addr)
        hpr_pkg::REG_PROP_GAIN:     prop_gain_r <= cfg_data;
        hpr_pkg::REG_DAMP_GAIN:     damp_gain_r <= cfg_data;
        hpr_pkg::REG_INV_STEP_TIME: inv_step_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // heading difference, turn sign and fold
  always_comb begin
    diff     = $signed({1'b0, deg_l_r}) - $signed({1'b0, deg_r_r});
    mag      = diff[16] ? 16'(-diff) : diff[15:0];
    far      = (mag >= hpr_pkg::DEG180_Q7);
    err_nxt  = far ? (hpr_pkg::DEG360_Q7 - mag) : mag;
    prev_sel = slot_ok_r ? prev_mag_r[slot_r] : 16'd0;
    der_sel  = slot_ok_r ? last_der_r[slot_r] : '0;
  end

  always_comb begin
    d_full = delta_r * $signed({1'b0, inv_step_r});
    if (d_full > 34'(hpr_pkg::CMD_MAX)) begin
      d_sat = hpr_pkg::CMD_MAX;
    end else if (d_full < 34'(hpr_pkg::CMD_MIN)) begin
      d_sat = hpr_pkg::CMD_MIN;
    end else begin
      d_sat = d_full[CW-1:0];
    end
    // zero stored magnitude keeps the last derivative
    deriv_nxt = prev_nz_r ? d_sat : old_der_r;
  end

  always_comb begin
    dd   = $signed({1'b0, damp_gain_r}) * deriv_r;
    sum  = $signed({10'd0, kp_r}) + 42'(dd);
    v    = plus_r ? sum : -sum;
    vabs = v[41] ? 42'(-v) : 42'(v);
  end

  // |v| of 2^31 or more always saturates after the pi/180 scale
  always_comb begin
    scaled = 42'(mag31_r) * 42'(hpr_pkg::RAD_PER_DEG_Q16) + 42'(1 << 17);
    m      = scaled[41:18];
    if (neg_r) begin
      if (big_r || m > 24'd8388608) begin
        cmd_nxt = hpr_pkg::CMD_MIN;
      end else begin
        cmd_nxt = 24'(-m);
      end
    end else begin
      if (big_r || m > 24'd8388607) begin
        cmd_nxt = hpr_pkg::CMD_MAX;
      end else begin
        cmd_nxt = m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      slot_r    <= in_tdata[SW-1:0];
      slot_ok_r <= (7'(in_tdata[SW-1:0]) < 7'(hpr_pkg::ROBOT_SLOTS));
      lead_r    <= in_tdata[SW+15:SW];
      robo_r    <= in_tdata[SW+31:SW+16];
    end
    if (cmd.conv) begin
      deg_l_r <= hpr_pkg::to_degrees(lead_r);
      deg_r_r <= hpr_pkg::to_degrees(robo_r);
    end
    if (cmd.err) begin
      err_r     <= err_nxt;
      plus_r    <= diff[16] ? far : !far;
      prev_nz_r <= (prev_sel != 16'd0);
      old_der_r <= der_sel;
      delta_r   <= $signed({1'b0, err_nxt}) - $signed({1'b0, prev_sel});
    end
    if (cmd.deriv) begin
      deriv_r <= deriv_nxt;
      kp_r    <= 32'(err_r) * 32'(prop_gain_r);
    end
    if (cmd.sum) begin
      mag31_r <= vabs[30:0];
      big_r   <= |vabs[41:31];
      neg_r   <= v[41];
    end
    if (cmd.out_load) begin
      out_slot_r <= slot_r;
      out_cmd_r  <= cmd_nxt;
      out_cw_r   <= plus_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < hpr_pkg::ROBOT_SLOTS; i++) begin
        prev_mag_r[i] <= '0;
        last_der_r[i] <= '0;
      end
    end else if (cmd.deriv && slot_ok_r) begin
      prev_mag_r[slot_r] <= err_r;
      last_der_r[slot_r] <= deriv_nxt;
    end
  end

  assign out_tdata = {3'd0, out_cw_r, out_cmd_r, out_slot_r};

endmodule

[design/heading_pd_rotation_command_core.sv]
// ----------------------------------------------------------------------------
// heading_pd_rotation_command_core: per-robot PD heading controller
// Wraps leader and follower headings to degrees, folds the error, keeps a
// per-slot derivative and produces a saturated rotation command.
//
//   channel  direction  payload (low bit up)
//   in_      slave      robot_slot[3:0], leader_heading[19:4], robot_heading[35:20]
//   out_     master     slot_echo[3:0], rotation_command[27:4], turn_clockwise[28]
//   cfg_     slave      cfg_addr = register index, cfg_data = 16-bit value
//
// An item is accepted in the idle step; five controller steps follow (convert,
// error, derivative, sum, scale), each at most one multiplier deep; the result
// is loaded into the output register at the scale step, and a new item is
// taken only after that. The result then sits in that register, so the
// next item is accepted while it waits; a stalled output stops the core at
// the scale step. Reset is synchronous and clears gains to defaults and all
// slot state.
// ----------------------------------------------------------------------------
module heading_pd_rotation_command_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // robot_slot, leader_heading, robot_heading, zero pad
  input  logic [hpr_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // slot_echo, rotation_command, turn_clockwise, zero pad
  output logic [hpr_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_addr,
  input  logic [15:0]                         cfg_data
);

  hpr_pkg::hpr_cmd_t cmd;

  assign cfg_ready = 1'b1;

  hpr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  hpr_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .cfg_wr    (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata)
  );

endmodule

[tb/heading_pd_rotation_command_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heading_pd_rotation_command_core_tb: self-checking bench for the PD heading core
// Drives heading pairs on the input stream and gain/rate writes on the cfg
// port. A scoreboard predicts each rotation command from its own copy of the
// gains and per-slot error history and checks every output item in order.
// Both stream sides idle at random; one long output hold-off fills the core.
// ----------------------------------------------------------------------------
module heading_pd_rotation_command_core_tb;

  localparam int RESET_CYCLES  = 9;
  localparam int IDLE_PCT      = 31;
  localparam int PHASE_ITEMS   = 190;
  localparam int NUM_PHASES    = 6;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 120;
  localparam int HOLD_AT_ITEM  = 500;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_MAX    = 10;

  // index with no register behind it
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int     HEAD_LIM    = 25736;
  localparam int     TWO_PI      = int'(hpr_pkg::TWO_PI_Q13);
  localparam longint DEG_PER_RAD = longint'(hpr_pkg::DEG_PER_RAD_Q16);
  localparam int     DEG180      = int'(hpr_pkg::DEG180_Q7);
  localparam int     DEG360      = int'(hpr_pkg::DEG360_Q7);
  localparam longint RAD_PER_DEG = longint'(hpr_pkg::RAD_PER_DEG_Q16);
  localparam int     CMD_HI      = 8388607;
  localparam int     CMD_LO      = -8388608;

  typedef struct {
    logic [3:0]  slot;
    logic [23:0] cmd;
    logic        cw;
  } rot_cmd_t;

  class rotation_cmd_scoreboard;
    int prop_k  = int'(hpr_pkg::PROP_GAIN_RST);
    int damp_k  = int'(hpr_pkg::DAMP_GAIN_RST);
    int rate_hz = int'(hpr_pkg::INV_STEP_TIME_RST);
    int prev_mag[hpr_pkg::ROBOT_SLOTS];
    int last_rate[hpr_pkg::ROBOT_SLOTS];
    rot_cmd_t pending_cmds[$];
    int mismatches = 0;

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        hpr_pkg::REG_PROP_GAIN:     prop_k = int'(val);
        hpr_pkg::REG_DAMP_GAIN:     damp_k = int'(val);
        hpr_pkg::REG_INV_STEP_TIME: rate_hz = int'(val);
        default: ;
      endcase
    endfunction

    // Q2.13 rad to Q9.7 deg, negatives lifted by a full turn first
    function int heading_deg(logic signed [15:0] rad);
      longint r;
      r = longint'(rad);
      if (r < 0) r += TWO_PI;
      return int'((r * DEG_PER_RAD + (longint'(1) << 21)) >>> 22);
    endfunction

    function rot_cmd_t predict_command(logic [3:0] slot, logic signed [15:0] lead,
                                       logic signed [15:0] rob);
      rot_cmd_t res;
      int diff, mag, err, prev, deriv;
      bit plus, neg;
      longint d, sum, m;
      diff = heading_deg(lead) - heading_deg(rob);
      mag = (diff < 0) ? -diff : diff;
      plus = (diff >= 0) ? (mag < DEG180) : (mag >= DEG180);
      err = (mag >= DEG180) ? (DEG360 - mag) : mag;
      prev = prev_mag[slot];
      deriv = last_rate[slot];
      // zero stored error: derivative of the slot is carried over
      if (prev != 0) begin
        d = longint'(err - prev) * longint'(rate_hz);
        if (d > CMD_HI) d = CMD_HI;
        if (d < CMD_LO) d = CMD_LO;
        deriv = int'(d);
      end
      prev_mag[slot] = err;
      last_rate[slot] = deriv;
      sum = longint'(prop_k) * err + longint'(damp_k) * deriv;
      if (!plus) sum = -sum;
      neg = (sum < 0);
      m = neg ? -sum : sum;
      m = (m * RAD_PER_DEG + (longint'(1) << 17)) >>> 18;
      if (neg) begin
        if (m > -longint'(CMD_LO)) m = -longint'(CMD_LO);
        res.cmd = 24'(-m);
      end else begin
        if (m > CMD_HI) m = CMD_HI;
        res.cmd = 24'(m);
      end
      res.slot = slot;
      res.cw = plus;
      return res;
    endfunction

    function void note_heading_pair(logic [3:0] slot, logic signed [15:0] lead,
                                    logic signed [15:0] rob);
      pending_cmds.insert(pending_cmds.size(), predict_command(slot, lead, rob));
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("mismatch %s: expected %h got %h", what, want, got);
    endfunction

    function void check_command(logic [31:0] tdata);
      rot_cmd_t want;
      if (pending_cmds.size() == 0) begin
        report("item with nothing pending", 32'h0, tdata);
        return;
      end
      want = pending_cmds.pop_front();
      if (tdata[3:0] !== want.slot) report("slot_echo", 32'(want.slot), 32'(tdata[3:0]));
      if (tdata[27:4] !== want.cmd)
        report("rotation_command", 32'(want.cmd), 32'(tdata[27:4]));
      if (tdata[28] !== want.cw) report("turn_clockwise", 32'(want.cw), 32'(tdata[28]));
      if (tdata[31:29] !== 3'b000) report("pad", 32'h0, 32'(tdata[31:29]));
    endfunction

    function int pending();
      return pending_cmds.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [hpr_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [hpr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [1:0]                      cfg_addr = hpr_pkg::REG_PROP_GAIN;
  logic [15:0]                     cfg_data = '0;

  rotation_cmd_scoreboard sb = new();
  int n_accepted = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;
  bit hold_armed = 1'b1;
  int hold_left = 0;
  int track_lead[hpr_pkg::ROBOT_SLOTS];
  int track_rob[hpr_pkg::ROBOT_SLOTS];
  int corner_heads[7] = '{-32768, -25736, -1, 0, 1, 25736, 32767};

  heading_pd_rotation_command_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // output side: random stalls, plus one long hold-off mid run
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_armed && n_accepted >= HOLD_AT_ITEM) begin
        hold_armed = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_command(out_tdata);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_heading(logic [3:0] slot, logic signed [15:0] lead,
                              logic signed [15:0] rob);
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0000, rob, lead, slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_heading_pair(slot, lead, rob);
    n_accepted++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_gains(logic [15:0] prop, logic [15:0] damp, logic [15:0] rate);
    write_reg(hpr_pkg::REG_PROP_GAIN, prop);
    write_reg(hpr_pkg::REG_DAMP_GAIN, damp);
    write_reg(hpr_pkg::REG_INV_STEP_TIME, rate);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int wrap_head(int h);
    if (h > HEAD_LIM) h -= TWO_PI;
    else if (h < -HEAD_LIM) h += TWO_PI;
    return h;
  endfunction

  // mostly slowly moving headings per slot, so the derivative path sees
  // realistic small steps; the rest is uniform, raw 16-bit, equal-pair and corner values
  task automatic random_heading_item();
    int slot, pick, lead, rob;
    slot = $urandom_range(hpr_pkg::ROBOT_SLOTS - 1);
    pick = $urandom_range(99);
    if (pick < 60) begin
      lead = wrap_head(track_lead[slot] + int'($urandom_range(800)) - 400);
      rob = wrap_head(track_rob[slot] + int'($urandom_range(800)) - 400);
    end else if (pick < 80) begin
      lead = int'($urandom_range(2 * HEAD_LIM)) - HEAD_LIM;
      rob = int'($urandom_range(2 * HEAD_LIM)) - HEAD_LIM;
    end else if (pick < 90) begin
      lead = int'($urandom_range(65535)) - 32768;
      rob = int'($urandom_range(65535)) - 32768;
    end else if (pick < 95) begin
      lead = int'($urandom_range(2 * HEAD_LIM)) - HEAD_LIM;
      rob = lead;
    end else begin
      lead = corner_heads[$urandom_range(6)];
      rob = corner_heads[$urandom_range(6)];
    end
    track_lead[slot] = lead;
    track_rob[slot] = rob;
    send_heading(4'(slot), 16'(lead), 16'(rob));
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_gains(16'd256, 16'd40, 16'd100);
    send_heading(4'd0, 16'sd0, 16'sd0);
    // exactly half a turn apart, both directions
    send_heading(4'd0, 16'sd25736, 16'sd0);
    send_heading(4'd0, 16'sd0, 16'sd25736);
    send_heading(4'd0, 16'sd4096, 16'sd0);
    send_heading(4'd15, -16'sd25736, 16'sd25736);
    // headings past +/- pi
    send_heading(4'd15, 16'sd32767, -16'sd32768);
    send_heading(4'd15, -16'sd32768, 16'sd32767);
    // wrap around zero
    send_heading(4'd15, -16'sd1, 16'sd1);
    send_heading(4'd15, 16'sd1, -16'sd1);
    send_heading(4'd3, 16'sd100, 16'sd100);
    send_heading(4'd3, 16'sd8000, -16'sd8000);
    // build a derivative, zero the error, then the held derivative is reused
    send_heading(4'd7, 16'sd1000, 16'sd0);
    send_heading(4'd7, 16'sd3000, 16'sd0);
    send_heading(4'd7, 16'sd0, 16'sd0);
    send_heading(4'd7, 16'sd2000, 16'sd0);
    send_heading(4'd9, 16'sd25735, -16'sd25736);
    send_heading(4'd9, 16'sd12868, -16'sd12868);
    send_heading(4'd2, 16'sh5555, 16'shAAAA);
    send_heading(4'd2, 16'shAAAA, 16'sh5555);
    send_heading(4'd8, -16'sd25736, -16'sd25736);
    send_heading(4'd8, 16'sd25736, 16'sd25736);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
        1: set_gains(16'd0, 16'd0, 16'd1);
        2: set_gains(16'd256, 16'd512, 16'd100);
        3: set_gains(16'($urandom), 16'($urandom), 16'd0);
        4: set_gains(16'd1, 16'hFFFF, 16'hFFFF);
        default: begin
          write_reg(REG_UNUSED, 16'($urandom));
          set_gains(16'($urandom), 16'($urandom), 16'($urandom_range(65535, 1)));
        end
      endcase
      no_idle = (ph == 3);
      repeat (PHASE_ITEMS) random_heading_item();
      drain();
    end
    no_idle = 1'b0;

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
